// ===== rtl/trt_pkg.sv =====
// Shared types and constants of the type registry table.
// Used by trt_cell, trt_chain and type_registry_table_core; depends on nothing.
package trt_pkg;

    localparam int GENERAL_SLOTS_DEF = 64;
    localparam int TOTAL_SLOTS_DEF   = 128;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_GET  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD        = 2'd1,
        ST_OVERFLOW   = 2'd2,
        ST_NOT_LOADED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_GEN,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [31:0] tag;
        logic [63:0] handler;
        logic [31:0] size;
        logic [63:0] length;
    } entry_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] code;
        logic        hit;
        entry_t      data;
    } probe_t;

endpackage

// ===== rtl/trt_cell.sv =====
// One private slot of the registry: holds a descriptor and passes a search probe on.
// Depends on trt_pkg.
module trt_cell
    import trt_pkg::*;
#(
    parameter int IDX_W = 6,
    parameter int INDEX = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  probe_t           probe_in,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  entry_t           wr_data,
    output probe_t           probe_out
);

    logic   used_reg;
    entry_t entry_reg;
    probe_t probe_reg;
    probe_t probe_next;
    logic   match;
    logic   sel;

    assign sel   = wr_en && (wr_idx == IDX_W'(INDEX));
    assign match = probe_in.valid && used_reg && !probe_in.hit
                   && (entry_reg.tag == probe_in.code);

    always_comb
    begin
        probe_next = probe_in;
        if (match)
        begin
            probe_next.hit  = 1'b1;
            probe_next.data = entry_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= 1'b0;
            probe_reg <= '0;
        end
        else
        begin
            if (sel)
            begin
                used_reg <= 1'b1;
            end
            probe_reg <= probe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel)
        begin
            entry_reg <= wr_data;
        end
    end

    assign probe_out = probe_reg;

endmodule

// ===== rtl/trt_chain.sv =====
// Row of private-slot cells; a probe enters at the first cell and leaves the last.
// Depends on trt_pkg and trt_cell.
module trt_chain
    import trt_pkg::*;
#(
    parameter int CELLS = 64,
    parameter int IDX_W = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  probe_t           probe_in,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  entry_t           wr_data,
    output probe_t           probe_out
);

    probe_t links [CELLS+1];

    assign links[0]  = probe_in;
    assign probe_out = links[CELLS];

    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        trt_cell #(
            .IDX_W (IDX_W),
            .INDEX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .probe_in  (links[i]),
            .wr_en     (wr_en),
            .wr_idx    (wr_idx),
            .wr_data   (wr_data),
            .probe_out (links[i+1])
        );
    end

endmodule

// ===== rtl/type_registry_table_core.sv =====
// Top level of the type registry table: control, general slot memory and output register.
// Depends on trt_pkg and trt_chain.
//
// Usage: a request on the in channel is either a load or a get of a type descriptor.
// Each request gives exactly one result on the out channel, with a status and, for a
// successful get, the descriptor found. One request is worked on at a time; in_ready is
// high only while no request is in progress.
// From acceptance to out_valid: a rejected request is decided in S_EVAL and goes straight
// to S_DONE, a general code takes one registered read of the general slot memory (S_EVAL,
// then S_GEN), and a private code sends a search probe that walks through the chain of
// private cells one cell per cycle, where CELLS is TOTAL_SLOTS - GENERAL_SLOTS. In S_DONE
// the result enters the output register; a new request can be accepted in the cycle after
// that; no new request is taken before the last result has entered that register.
// Reset clears all valid bits, so every general slot reads as zeros and general slot 0 counts as
// loaded; no clearing pass is needed. If the receiver stalls, the result waits in the
// output register and the next result waits in the block until it drains.
module type_registry_table_core
    import trt_pkg::*;
#(
    parameter int GENERAL_SLOTS = GENERAL_SLOTS_DEF,
    parameter int TOTAL_SLOTS   = TOTAL_SLOTS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               command,
    input  logic signed [31:0] type_code,
    input  logic        [63:0] handler_handle,
    input  logic signed [31:0] byte_size,
    input  logic        [63:0] length_handle,
    output logic               out_valid,
    input  logic               out_ready,
    output logic        [1:0]  status,
    output logic signed [31:0] found_type,
    output logic        [63:0] found_handler,
    output logic signed [31:0] found_size,
    output logic        [63:0] found_length
);

    localparam int PRIVATE_CAP = (TOTAL_SLOTS > GENERAL_SLOTS) ? (TOTAL_SLOTS - GENERAL_SLOTS) : 0;
    localparam int CELLS  = (PRIVATE_CAP > 0) ? PRIVATE_CAP : 1;
    localparam int IDX_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CNT_W  = (PRIVATE_CAP > 0) ? $clog2(PRIVATE_CAP + 1) : 1;
    localparam int GIDX_W = (GENERAL_SLOTS > 1) ? $clog2(GENERAL_SLOTS) : 1;

    state_t      state_reg;
    state_t      state_next;

    logic        req_cmd_reg;
    logic [31:0] req_code_reg;
    entry_t      req_entry_reg;

    logic [CNT_W-1:0] used_reg;

    entry_t      gen_mem [GENERAL_SLOTS];
    logic        gen_valid_reg [GENERAL_SLOTS];
    entry_t      gen_rd_reg;
    logic        gen_rd_valid_reg;
    entry_t      gen_entry;
    logic [GIDX_W-1:0] gen_addr;

    probe_t      probe_in;
    probe_t      probe_out;

    status_t     res_status_reg;
    status_t     res_status_next;
    entry_t      res_entry_reg;
    entry_t      res_entry_next;

    logic        out_valid_reg;
    status_t     out_status_reg;
    entry_t      out_entry_reg;

    logic        is_bad;
    logic        is_full;
    logic        is_general;
    logic        gen_re;
    logic        gen_we;
    logic        probe_launch;
    logic        cell_we;
    logic        res_load;
    logic        out_load;

    assign in_ready   = (state_reg == S_IDLE);
    assign gen_addr   = req_code_reg[GIDX_W-1:0];
    assign gen_entry  = gen_rd_valid_reg ? gen_rd_reg : '0;
    assign is_full    = (used_reg >= CNT_W'(PRIVATE_CAP));
    assign is_general = (req_code_reg < 32'(GENERAL_SLOTS));
    assign is_bad     = req_code_reg[31] ||
                        ((req_cmd_reg == CMD_LOAD) &&
                         ((req_entry_reg.handler == 64'd0) || req_entry_reg.size[31]));
    assign out_load   = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                priority if (is_bad)
                begin
                    state_next = S_DONE;
                end
                else if ((req_cmd_reg == CMD_LOAD) && is_full)
                begin
                    state_next = S_DONE;
                end
                else if (is_general)
                begin
                    state_next = S_GEN;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_GEN:
            begin
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                if (probe_out.valid)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        gen_re          = 1'b0;
        gen_we          = 1'b0;
        probe_launch    = 1'b0;
        cell_we         = 1'b0;
        res_load        = 1'b0;
        res_status_next = ST_OK;
        res_entry_next  = '0;
        unique case (state_reg)
            S_EVAL:
            begin
                priority if (is_bad)
                begin
                    res_load        = 1'b1;
                    res_status_next = ST_BAD;
                end
                else if ((req_cmd_reg == CMD_LOAD) && is_full)
                begin
                    res_load        = 1'b1;
                    res_status_next = ST_OVERFLOW;
                end
                else if (is_general)
                begin
                    gen_re = 1'b1;
                end
                else
                begin
                    probe_launch = 1'b1;
                end
            end
            S_GEN:
            begin
                res_load = 1'b1;
                if (req_cmd_reg == CMD_LOAD)
                begin
                    gen_we = (gen_entry.tag != req_code_reg);
                end
                else if (gen_entry.tag == req_code_reg)
                begin
                    res_entry_next = gen_entry;
                end
                else
                begin
                    res_status_next = ST_NOT_LOADED;
                end
            end
            S_SCAN:
            begin
                if (probe_out.valid)
                begin
                    res_load = 1'b1;
                    if (req_cmd_reg == CMD_LOAD)
                    begin
                        cell_we = !probe_out.hit;
                    end
                    else if (probe_out.hit)
                    begin
                        res_entry_next = probe_out.data;
                    end
                    else
                    begin
                        res_status_next = ST_NOT_LOADED;
                    end
                end
            end
            S_IDLE, S_DONE:
            begin
                res_load = 1'b0;
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        probe_in       = '0;
        probe_in.valid = probe_launch;
        probe_in.code  = req_code_reg;
    end

    trt_chain #(
        .CELLS (CELLS),
        .IDX_W (IDX_W)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .probe_in  (probe_in),
        .wr_en     (cell_we),
        .wr_idx    (used_reg[IDX_W-1:0]),
        .wr_data   (req_entry_reg),
        .probe_out (probe_out)
    );

    always_ff @(posedge clk)
    begin
        if (gen_we)
        begin
            gen_mem[gen_addr] <= req_entry_reg;
        end
        if (gen_re)
        begin
            gen_rd_reg <= gen_mem[gen_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            used_reg         <= '0;
            gen_rd_valid_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < GENERAL_SLOTS; i++)
            begin
                gen_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cell_we)
            begin
                used_reg <= used_reg + CNT_W'(1);
            end
            if (gen_we)
            begin
                gen_valid_reg[gen_addr] <= 1'b1;
            end
            if (gen_re)
            begin
                gen_rd_valid_reg <= gen_valid_reg[gen_addr];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_cmd_reg           <= command;
            req_code_reg          <= type_code;
            req_entry_reg.tag     <= type_code;
            req_entry_reg.handler <= handler_handle;
            req_entry_reg.size    <= byte_size;
            req_entry_reg.length  <= length_handle;
        end
        if (res_load)
        begin
            res_status_reg <= res_status_next;
            res_entry_reg  <= res_entry_next;
        end
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_entry_reg  <= res_entry_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign found_type    = out_entry_reg.tag;
    assign found_handler = out_entry_reg.handler;
    assign found_size    = out_entry_reg.size;
    assign found_length  = out_entry_reg.length;

    // The fill count never passes the number of private cells.
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(PRIVATE_CAP))
        else $error("private fill count exceeds capacity");

    // A probe only leaves the chain while the controller waits for it.
    a_probe_exit: assert property (@(posedge clk) disable iff (!rst_n)
        probe_out.valid |-> (state_reg == S_SCAN))
        else $error("search probe left the chain outside a scan");

    // A private append never happens when the section is full.
    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        cell_we |-> !is_full)
        else $error("append into a full private section");

    // A result moves to the output register only after the previous one has drained.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !out_load)
        else $error("output register overwritten while stalled");

endmodule
